[rtl/core/wsd_pkg.sv]
package wsd_pkg;

  // Result kinds as they appear on the kind output.
  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindEmpty = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  // Protocol error codes, in the order in which they are checked.
  localparam logic [2:0] ErrUnmasked = 3'd0;
  localparam logic [2:0] ErrNotFinal = 3'd1;
  localparam logic [2:0] ErrReserved = 3'd2;
  localparam logic [2:0] ErrLen64    = 3'd3;
  localparam logic [2:0] ErrTooLong  = 3'd4;

  // Header constants.
  localparam logic [6:0]  LenCode16      = 7'd126;
  localparam logic [6:0]  LenCode64      = 7'd127;
  localparam logic [15:0] MaxLengthReset = 16'd2048;

  // Result queue between the parser and the output stage.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // One classified result on its way to the output stage. The payload byte
  // still carries its mask; the output stage removes it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  raw;
    logic [7:0]  key;
    logic [3:0]  opcode;
    logic        last;
    logic [15:0] length;
    logic [2:0]  err;
  } item_t;

  // Push from the parser into the queue.
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

[rtl/core/wsd_front.sv]
module wsd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic [7:0]     raw_byte_i,
  input  logic           accept_i,
  output wsd_pkg::push_t push_o
);

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExtHi,
    PhExtLo,
    PhMask,
    PhData,
    PhDead
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] len_q, len_d;
  logic [15:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  pos_q, pos_d;
  logic [15:0] max_len_q;

  logic [6:0]  len_code;
  logic [15:0] ext_len;
  logic [7:0]  key_byte;

  assign len_code = raw_byte_i[6:0];
  assign ext_len  = {len_q[15:8], raw_byte_i};

  // Mask key byte for the current payload position, first key byte first.
  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Header parsing, error checks and payload classification.
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    flags_d  = flags_q;
    len_d    = len_q;
    remain_d = remain_q;
    key_d    = key_q;
    pos_d    = pos_q;

    push_o.valid       = 1'b0;
    push_o.item.kind   = wsd_pkg::KindError;
    push_o.item.raw    = raw_byte_i;
    push_o.item.key    = key_byte;
    push_o.item.opcode = opcode_q;
    push_o.item.last   = 1'b0;
    push_o.item.length = '0;
    push_o.item.err    = wsd_pkg::ErrUnmasked;

    if (accept_i) begin
      case (phase_q)
        PhHdr0: begin
          opcode_d = raw_byte_i[3:0];
          flags_d  = raw_byte_i[7:4];
          len_d    = '0;
          phase_d  = PhHdr1;
        end
        PhHdr1: begin
          if (!raw_byte_i[7]) begin
            push_o.valid    = 1'b1;
            push_o.item.err = wsd_pkg::ErrUnmasked;
            phase_d         = PhDead;
          end else if (!flags_q[3]) begin
            push_o.valid    = 1'b1;
            push_o.item.err = wsd_pkg::ErrNotFinal;
            phase_d         = PhDead;
          end else if (flags_q[2:0] != 3'd0) begin
            push_o.valid    = 1'b1;
            push_o.item.err = wsd_pkg::ErrReserved;
            phase_d         = PhDead;
          end else if (len_code == wsd_pkg::LenCode64) begin
            push_o.valid    = 1'b1;
            push_o.item.err = wsd_pkg::ErrLen64;
            phase_d         = PhDead;
          end else if (len_code == wsd_pkg::LenCode16) begin
            phase_d = PhExtHi;
          end else begin
            len_d = {9'd0, len_code};
            if ({9'd0, len_code} > max_len_q) begin
              push_o.valid       = 1'b1;
              push_o.item.err    = wsd_pkg::ErrTooLong;
              push_o.item.length = {9'd0, len_code};
              phase_d            = PhDead;
            end else begin
              pos_d   = '0;
              phase_d = PhMask;
            end
          end
        end
        PhExtHi: begin
          len_d   = {raw_byte_i, 8'd0};
          phase_d = PhExtLo;
        end
        PhExtLo: begin
          len_d = ext_len;
          if (ext_len > max_len_q) begin
            push_o.valid       = 1'b1;
            push_o.item.err    = wsd_pkg::ErrTooLong;
            push_o.item.length = ext_len;
            phase_d            = PhDead;
          end else begin
            pos_d   = '0;
            phase_d = PhMask;
          end
        end
        PhMask: begin
          key_d = {key_q[23:0], raw_byte_i};
          if (pos_q != 2'd3) begin
            pos_d = pos_q + 2'd1;
          end else begin
            pos_d = '0;
            if (len_q == 16'd0) begin
              push_o.valid     = 1'b1;
              push_o.item.kind = wsd_pkg::KindEmpty;
              push_o.item.last = 1'b1;
              phase_d          = PhHdr0;
            end else begin
              remain_d = len_q;
              phase_d  = PhData;
            end
          end
        end
        PhData: begin
          pos_d              = pos_q + 2'd1;
          remain_d           = remain_q - 16'd1;
          push_o.valid       = 1'b1;
          push_o.item.kind   = wsd_pkg::KindData;
          push_o.item.length = len_q;
          push_o.item.last   = (remain_q == 16'd1);
          if (remain_q == 16'd1) begin
            phase_d = PhHdr0;
          end
        end
        default: begin
          // After an error every byte is dropped until reset.
          phase_d = PhDead;
        end
      endcase
    end
  end

  // Parser state and the length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHdr0;
      opcode_q  <= '0;
      flags_q   <= '0;
      len_q     <= '0;
      remain_q  <= '0;
      pos_q     <= '0;
      max_len_q <= wsd_pkg::MaxLengthReset;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      flags_q  <= flags_d;
      len_q    <= len_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // The mask key is always fully loaded before payload bytes use it.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[rtl/core/wsd_queue.sv]
module wsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wsd_pkg::push_t push_i,
  output logic           full_o,
  output logic           avail_o,
  output wsd_pkg::item_t head_o,
  input  logic           pop_i
);

  localparam logic [wsd_pkg::QueueAw:0] DepthCount = (wsd_pkg::QueueAw + 1)'(wsd_pkg::QueueDepth);

  wsd_pkg::item_t              mem_q [wsd_pkg::QueueDepth];
  logic [wsd_pkg::QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [wsd_pkg::QueueAw:0]   count_q;
  logic                        do_push, do_pop;

  assign full_o  = (count_q == DepthCount);
  assign avail_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && avail_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

[rtl/core/wsd_back.sv]
module wsd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  wsd_pkg::item_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     data_out_o,
  output logic [3:0]     frame_opcode_o,
  output logic           last_byte_o,
  output logic [15:0]    frame_length_o,
  output logic [2:0]     error_code_o
);

  logic        valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  data_q;
  logic [3:0]  opcode_q;
  logic        last_q;
  logic [15:0] length_q;
  logic [2:0]  err_q;
  logic [7:0]  data_d;

  // Take the queue head whenever the output register is empty or draining.
  assign pop_o = avail_i && (!valid_q || out_ready_i);

  // Remove the mask from payload bytes; other kinds carry zero data.
  assign data_d = (head_i.kind == wsd_pkg::KindData) ? (head_i.raw ^ head_i.key) : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= head_i.kind;
      data_q   <= data_d;
      opcode_q <= head_i.opcode;
      last_q   <= head_i.last;
      length_q <= head_i.length;
      err_q    <= head_i.err;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = kind_q;
  assign data_out_o     = data_q;
  assign frame_opcode_o = opcode_q;
  assign last_byte_o    = last_q;
  assign frame_length_o = length_q;
  assign error_code_o   = err_q;

endmodule

[rtl/core/websocket_frame_deframer.sv]
// WebSocket client-to-server deframer: takes one received byte per transaction, parses the
// header, extended length and mask key, and emits each payload byte unmasked with its opcode,
// frame length and a last-byte mark; a zero-length frame gives one empty-frame result and a
// protocol error is reported once, after which all bytes are dropped until reset. One byte is
// accepted every cycle as long as the four-entry result queue is not full; each result is
// registered in the result queue and then in the output register. The length limit may be
// written through cfg_we_i only while no transaction is in flight.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  raw_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_out_o,
  output logic [3:0]  frame_opcode_o,
  output logic        last_byte_o,
  output logic [15:0] frame_length_o,
  output logic [2:0]  error_code_o
);

  wsd_pkg::push_t push;
  wsd_pkg::item_t head;
  logic           full, avail, pop, accept;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  // Parser: header fields, mask key and classification of each byte.
  wsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .raw_byte_i  (raw_byte_i),
    .accept_i    (accept),
    .push_o      (push)
  );

  // Result queue.
  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .avail_o (avail),
    .head_o  (head),
    .pop_i   (pop)
  );

  // Unmasking and output register.
  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (avail),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_out_o     (data_out_o),
    .frame_opcode_o (frame_opcode_o),
    .last_byte_o    (last_byte_o),
    .frame_length_o (frame_length_o),
    .error_code_o   (error_code_o)
  );

endmodule

[rtl/core/wsd_checker.sv]
module wsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  data_out_o,
  input logic        last_byte_o,
  input logic [15:0] frame_length_o,
  input logic [2:0]  error_code_o
);

  // A stalled result transaction keeps its kind and data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(data_out_o))
    else $error("stalled result changed");

  // Only payload bytes carry data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != wsd_pkg::KindData) |-> data_out_o == 8'd0)
    else $error("data on a non-payload result");

  // Empty frames are marked last and have zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == wsd_pkg::KindEmpty) |-> last_byte_o && frame_length_o == 16'd0)
    else $error("malformed empty-frame result");

  // Errors are never marked last; other kinds carry a zero error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == wsd_pkg::KindError) ? !last_byte_o : (error_code_o == 3'd0))
    else $error("inconsistent error fields");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .data_out_o     (data_out_o),
  .last_byte_o    (last_byte_o),
  .frame_length_o (frame_length_o),
  .error_code_o   (error_code_o)
);
